// ----- hw/rtl/tsts_pkg.sv -----
`timescale 1ns / 1ps

package tsts_pkg;

  typedef logic [3:0] twr_idx_t;
  typedef logic [15:0] twr_mask_t;

  localparam int SideHalfW = 16;
  localparam int SideCounted = 10;
  localparam int TopTiles = 25;
  localparam int TopRowLen = 5;
  localparam int TwrGrid = 4;

  // Towers along each side half, indexed by tile column
  localparam twr_idx_t XZ_PLUS_TWR  [4] = '{4'd12, 4'd13, 4'd14, 4'd15};
  localparam twr_idx_t XZ_MINUS_TWR [4] = '{4'd0,  4'd1,  4'd2,  4'd3};
  localparam twr_idx_t YZ_PLUS_TWR  [4] = '{4'd3,  4'd7,  4'd11, 4'd15};
  localparam twr_idx_t YZ_MINUS_TWR [4] = '{4'd0,  4'd4,  4'd8,  4'd12};

  // Input beat, last field in the low bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [11:0] cno_boards;
    logic [15:0] cal_low_towers;
    logic [15:0] cal_high_towers;
    logic [15:0] track_towers;
    logic [24:0] top_face_tiles;
    logic [31:0] yz_face_tiles;
    logic [31:0] xz_face_tiles;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic        req_cno;
    logic        req_cal_low;
    logic        req_cal_high;
    logic        req_track;
    logic        req_track_not_vetoed;
    twr_mask_t   shadowed_towers;
  } out_beat_t;

  // Side tile in column r shadows the towers at r-1 and r; tiles 10-15 unused
  function automatic twr_mask_t side_shadow(input logic [SideHalfW-1:0] tiles,
                                            input twr_idx_t twr [4]);
    twr_mask_t mask;
    int r;
    mask = '0;
    for (int t = 0; t < SideCounted; t++) begin
      r = t % TopRowLen;
      if (tiles[t]) begin
        if (r > 0) mask[twr[r-1]] = 1'b1;
        if (r < TwrGrid) mask[twr[r]] = 1'b1;
      end
    end
    return mask;
  endfunction

  // Top tile (i, j) sits over the corners of up to four towers
  function automatic twr_mask_t top_shadow(input logic [TopTiles-1:0] tiles);
    twr_mask_t mask;
    int r;
    int c;
    twr_idx_t idx;
    mask = '0;
    for (int t = 0; t < TopTiles; t++) begin
      for (int dr = 0; dr < 2; dr++) begin
        for (int dc = 0; dc < 2; dc++) begin
          r = t / TopRowLen + dr;
          c = t % TopRowLen + dc;
          if (tiles[t] && r >= 1 && r <= TwrGrid && c >= 1 && c <= TwrGrid) begin
            idx = twr_idx_t'(TwrGrid * (r - 1) + (c - 1));
            mask[idx] = 1'b1;
          end
        end
      end
    end
    return mask;
  endfunction

endpackage

// ----- hw/rtl/tile_shadow_trigger_summary.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Beat contents
// s_axis    in   tiles per face, tower trigger primitives, CNO boards
// m_axis    out  shadowed tower mask and five request flags
//
// Two register stages: input register, then the mask/flag logic into the
// output register. One beat per cycle unless m_axis stalls. rst clears
// both valid bits only. A stall on m_axis holds the output beat and lets
// one more beat wait in the input register.
module tile_shadow_trigger_summary import tsts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // xz_face_tiles[31:0], yz_face_tiles[63:32], top_face_tiles[88:64],
  // track_towers[104:89], cal_high_towers[120:105], cal_low_towers[136:121],
  // cno_boards[148:137], zero pad[151:149]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // shadowed_towers[15:0], req_track_not_vetoed[16], req_track[17],
  // req_cal_high[18], req_cal_low[19], req_cno[20], zero pad[23:21]
  output logic [23:0]  m_axis_tdata
);

  in_beat_t  in_reg;
  logic      in_valid;
  out_beat_t out_reg;
  out_beat_t out_next;
  logic      out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_free;

  always_comb begin
    out_next.pad = '0;
    out_next.shadowed_towers =
        side_shadow(in_reg.xz_face_tiles[31:16], XZ_PLUS_TWR)
      | side_shadow(in_reg.xz_face_tiles[15:0],  XZ_MINUS_TWR)
      | side_shadow(in_reg.yz_face_tiles[31:16], YZ_PLUS_TWR)
      | side_shadow(in_reg.yz_face_tiles[15:0],  YZ_MINUS_TWR)
      | top_shadow(in_reg.top_face_tiles);
    out_next.req_track_not_vetoed = |(in_reg.track_towers & out_next.shadowed_towers);
    out_next.req_track    = |in_reg.track_towers;
    out_next.req_cal_high = |in_reg.cal_high_towers;
    out_next.req_cal_low  = |in_reg.cal_low_towers;
    out_next.req_cno      = |in_reg.cno_boards;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_free) m_axis_tvalid <= in_valid;
    end
    if (s_axis_tready) in_reg <= in_beat_t'(s_axis_tdata);
    if (out_free) out_reg <= out_next;
  end

  assign m_axis_tdata = out_reg;

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> in_valid)
    else $error("accepted beat not held in input register");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_free) |=> m_axis_tvalid)
    else $error("input register beat did not reach output");

  a_veto_subset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_reg.req_track || !out_reg.req_track_not_vetoed))
    else $error("track-not-vetoed without any track flag");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stage empty but not ready");

endmodule
